// ===== rtl/utrt_pkg.sv =====
// Shared constants, types and the digit-to-character function of the radix text converter.
package utrt_pkg;

   // Defaults for the top-level parameters
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int MAX_WIDTH_DEFAULT  = 32;

   // Request field widths and packing
   localparam int REQ_VALUE_W = 32;
   localparam int REQ_RADIX_W = 6;
   localparam int REQ_WIDTH_W = 6;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 8;

   // Quotient bits resolved per divider cycle
   localparam int DIV_STEP = 4;

   // Legal radix range
   localparam logic [REQ_RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [REQ_RADIX_W-1:0] RADIX_MAX = 6'd36;

   // Characters
   localparam logic [7:0] PAD_CHAR   = 8'h30;
   localparam logic [7:0] ALPHA_BASE = 8'h61;
   localparam logic [5:0] DEC_DIGITS = 6'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_STORE,
      ST_SIZE,
      ST_EMIT,
      ST_ERR
   } utrt_state_type;

   // Controller to datapath
   typedef struct packed {
      logic start;
      logic div_step;
      logic digit_store;
      logic size;
      logic emit_next;
      logic show_err;
   } utrt_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic radix_bad;
      logic div_done;
      logic quot_zero;
      logic last_char;
   } utrt_status_type;

   // Digit value 0..35 to lower-case ASCII
   function automatic logic [7:0] digit_ascii(input logic [5:0] d);
      logic [7:0] ch;
      if (d < DEC_DIGITS) begin
         ch = PAD_CHAR + {2'b00, d};
      end else begin
         ch = ALPHA_BASE + {2'b00, d - DEC_DIGITS};
      end
      return ch;
   endfunction

endpackage

// ===== rtl/utrt_datapath.sv =====
// Datapath: digit-serial divider, digit stack, padding and character output.
module utrt_datapath import utrt_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic [REQ_VALUE_W-1:0] req_value,
   input  logic [REQ_RADIX_W-1:0] req_radix,
   input  logic [REQ_WIDTH_W-1:0] req_min_width,
   input  utrt_cmd_type           cmd,
   output utrt_status_type        stat,
   output logic [7:0]             rsp_char,
   output logic                   rsp_last,
   output logic                   rsp_bad
);

   localparam int VW         = (VALUE_BITS < REQ_VALUE_W) ? VALUE_BITS : REQ_VALUE_W;
   localparam int QW         = ((VW + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
   localparam int DIV_CYCLES = QW / DIV_STEP;
   localparam int CYC_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int NW         = $clog2(VW + 1);
   localparam int DIG_IW     = $clog2(VW);
   localparam int MAX_TOT    = (VW > MAX_WIDTH) ? VW : MAX_WIDTH;
   localparam int TOT_W      = $clog2(MAX_TOT + 1);

   logic [QW-1:0]          dvd_ff;
   logic [REQ_RADIX_W-1:0] rad_ff;
   logic [REQ_RADIX_W-1:0] rem_ff;
   logic [CYC_W-1:0]       cyc_ff;
   logic [NW-1:0]          ndig_ff;
   logic [TOT_W-1:0]       wid_ff;
   logic [TOT_W-1:0]       total_ff;
   logic [TOT_W-1:0]       pad_ff;
   logic [TOT_W-1:0]       k_ff;
   logic [5:0]             dig_ff [VW];

   logic [REQ_RADIX_W-1:0] rem_in;
   logic [DIV_STEP-1:0]    qbits;
   logic [REQ_RADIX_W:0]   part;
   logic [TOT_W-1:0]       wid_sat;
   logic [TOT_W-1:0]       ndig_ext;
   logic [TOT_W-1:0]       total_in;
   logic [TOT_W-1:0]       rd_full;
   logic [DIG_IW-1:0]      rd_idx;

   // Restoring division by the radix, DIV_STEP quotient bits per cycle
   always_comb begin
      rem_in = rem_ff;
      qbits  = '0;
      part   = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
         part = {rem_in, dvd_ff[QW-1-i]};
         if (part >= {1'b0, rad_ff}) begin
            part               = part - {1'b0, rad_ff};
            qbits[DIV_STEP-1-i] = 1'b1;
         end
         rem_in = part[REQ_RADIX_W-1:0];
      end
   end

   // Minimum width saturates at MAX_WIDTH
   assign wid_sat = ({1'b0, req_min_width} > 7'(MAX_WIDTH)) ? TOT_W'(MAX_WIDTH)
                                                            : TOT_W'(req_min_width);

   assign ndig_ext = TOT_W'(ndig_ff);
   assign total_in = (ndig_ext > wid_ff) ? ndig_ext : wid_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dvd_ff  <= QW'(req_value[VW-1:0]);
         rad_ff  <= req_radix;
         wid_ff  <= wid_sat;
         rem_ff  <= '0;
         cyc_ff  <= '0;
         ndig_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[QW-DIV_STEP-1:0], qbits};
         rem_ff <= rem_in;
         cyc_ff <= cyc_ff + CYC_W'(1);
      end else if (cmd.digit_store) begin
         dig_ff[ndig_ff[DIG_IW-1:0]] <= rem_ff;
         ndig_ff <= ndig_ff + NW'(1);
         rem_ff  <= '0;
         cyc_ff  <= '0;
      end else if (cmd.size) begin
         total_ff <= total_in;
         pad_ff   <= total_in - ndig_ext;
         k_ff     <= '0;
      end else if (cmd.emit_next) begin
         k_ff <= k_ff + TOT_W'(1);
      end
   end

   // Digits were stacked least significant first; read back from the top
   assign rd_full = total_ff - TOT_W'(1) - k_ff;
   assign rd_idx  = rd_full[DIG_IW-1:0];

   always_comb begin
      if (cmd.show_err) begin
         rsp_char = '0;
      end else if (k_ff < pad_ff) begin
         rsp_char = PAD_CHAR;
      end else begin
         rsp_char = digit_ascii(dig_ff[rd_idx]);
      end
   end

   assign rsp_last = cmd.show_err | stat.last_char;
   assign rsp_bad  = cmd.show_err;

   // Status back to the controller
   assign stat.radix_bad = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX);
   assign stat.div_done  = (cyc_ff == CYC_W'(DIV_CYCLES - 1));
   assign stat.quot_zero = (dvd_ff == '0);
   assign stat.last_char = (k_ff == total_ff - TOT_W'(1));

endmodule

// ===== rtl/utrt_ctrl.sv =====
// Controller: sequences accept, digit division, sizing and character output.
module utrt_ctrl import utrt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  utrt_status_type stat,
   output utrt_cmd_type    cmd
);

   utrt_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = stat.radix_bad ? ST_ERR : ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            state_in = stat.quot_zero ? ST_SIZE : ST_DIV;
         end
         ST_SIZE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready && stat.last_char) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs and datapath commands
   always_comb begin
      req_tready      = 1'b0;
      rsp_tvalid      = 1'b0;
      cmd             = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_STORE: begin
            cmd.digit_store = 1'b1;
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
         end
         ST_EMIT: begin
            rsp_tvalid    = 1'b1;
            cmd.emit_next = rsp_tready;
         end
         ST_ERR: begin
            rsp_tvalid   = 1'b1;
            cmd.show_err = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/unsigned_to_radix_text_core.sv =====
// Top level of the unsigned integer to radix text converter.
//
// A request carries a value, a radix (2..36) and a minimum width. The block
// answers with one response per character, most significant digit first,
// lower-case '0'-'9','a'-'z', left-padded with '0' to the minimum width
// (capped at MAX_WIDTH). The final character has rsp_tlast set. A radix
// outside 2..36 gives a single response with tdata zero, tlast and tuser set.
// Zero converts to a single '0' before padding.
// Each digit is found by the 4-bit-per-cycle restoring divide loop over the
// whole value, followed by a digit store step. One sizing step follows, then
// one character per cycle while rsp_tready is high.
// One request is handled at a time; req_tready is high only when idle.
// A low rsp_tready simply holds the current character. Synchronous reset
// returns the controller to idle and drops any request in progress.
module unsigned_to_radix_text_core import utrt_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // value[31:0], radix[37:32], min_width[43:38]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // digit_char[7:0]
   output logic                   rsp_tlast,
   output logic                   rsp_tuser    // bad_radix[0]
);

   utrt_cmd_type    cmd;
   utrt_status_type stat;

   utrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   utrt_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .req_value     (req_tdata[REQ_VALUE_W-1:0]),
      .req_radix     (req_tdata[REQ_VALUE_W +: REQ_RADIX_W]),
      .req_min_width (req_tdata[REQ_VALUE_W+REQ_RADIX_W +: REQ_WIDTH_W]),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_char      (rsp_tdata),
      .rsp_last      (rsp_tlast),
      .rsp_bad       (rsp_tuser)
   );

   // An error response is always a single, final character
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("error response not marked last or carries data");

   // Requests are taken only while no response is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request accepted while responses pending");

   // After the final character is taken the block is idle again
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not idle after final character");

endmodule
